>>> sv/stt_pkg.sv
package stt_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int LINE_BITS = 20;
  localparam int COLUMN_BITS = 16;
  localparam int LEN_BITS = 16;

  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

  typedef enum logic [3:0] {
    K_END    = 4'd0,
    K_LPAREN = 4'd1,
    K_RPAREN = 4'd2,
    K_LBRACE = 4'd3,
    K_RBRACE = 4'd4,
    K_COMMA  = 4'd5,
    K_STRING = 4'd6,
    K_INT    = 4'd7,
    K_IDENT  = 4'd8,
    K_BAD    = 4'd9,
    K_OPEN   = 4'd10
  } kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]             kind;
    logic [LINE_BITS-1:0]   start_line;
    logic [COLUMN_BITS-1:0] start_col;
    logic [LINE_BITS-1:0]   end_line;
    logic [COLUMN_BITS-1:0] end_col;
    logic [OFFSET_BITS-1:0] text_offset;
    logic [LEN_BITS-1:0]    text_length;
    logic [7:0]             bad_byte;
    logic                   last;
  } tok_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

endpackage

>>> sv/stt_in_if.sv
interface stt_in_if;
  import stt_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_end;
  modport source(output valid, ch, is_end, input ready);
  modport sink(input valid, ch, is_end, output ready);
endinterface

>>> sv/stt_out_if.sv
interface stt_out_if;
  import stt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [3:0]             kind;
  logic [LINE_BITS-1:0]   start_line;
  logic [COLUMN_BITS-1:0] start_col;
  logic [LINE_BITS-1:0]   end_line;
  logic [COLUMN_BITS-1:0] end_col;
  logic [OFFSET_BITS-1:0] text_offset;
  logic [LEN_BITS-1:0]    text_length;
  logic [7:0]             bad_byte;
  logic                   last;
  modport source(output valid, kind, start_line, start_col, end_line, end_col,
                 text_offset, text_length, bad_byte, last, input ready);
  modport sink(input valid, kind, start_line, start_col, end_line, end_col,
               text_offset, text_length, bad_byte, last, output ready);
endinterface

>>> sv/source_text_tokenizer.sv
// Source text tokenizer.
// in (stt_in_if sink): one source byte per transfer in ch, or an end-of-text
//   marker with is_end high. A transfer completes when valid and ready are high.
// out (stt_out_if source): one token per transfer with kind, start and end
//   position, text offset and length, the offending byte for bad char, and
//   last high on the final token caused by an input.
// Bytes pass a four-entry queue into the scanner, which takes one byte per
//   cycle unless held; the closing byte is queued, then the token registered.
// One byte per cycle is sustained while tokens are taken; an input that gives
//   two tokens holds the scanner while the second leaves.
// When the receiver stalls the output register and queue hold, and in.ready
//   falls once the queue is full.
// After a bad char, open string or end token the block discards all further
//   input until reset.
// Reset (rst, synchronous) empties the queue, drops any pending token and
//   returns to line 1, column 1, offset 0.
module source_text_tokenizer (
  input logic clk,
  input logic rst,
  stt_in_if.sink in,
  stt_out_if.source out
);
  import stt_pkg::*;

  in_item_t wr_data, q_data;
  logic q_valid, q_ready, stopped;
  tok_t tok;

  assign wr_data.ch = in.ch;
  assign wr_data.is_end = in.is_end;

  stt_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(in.valid), .wr_ready(in.ready), .wr_data(wr_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  stt_scan u_scan (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .out_valid(out.valid), .out_ready(out.ready), .out_data(tok),
    .stopped(stopped)
  );

  assign out.kind = tok.kind;
  assign out.start_line = tok.start_line;
  assign out.start_col = tok.start_col;
  assign out.end_line = tok.end_line;
  assign out.end_col = tok.end_col;
  assign out.text_offset = tok.text_offset;
  assign out.text_length = tok.text_length;
  assign out.bad_byte = tok.bad_byte;
  assign out.last = tok.last;

  a_bad_stops: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.ready && out.last &&
    (out.kind == K_BAD || out.kind == K_OPEN || out.kind == K_END) |=> stopped)
    else $error("terminal token did not stop scanner");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("stop flag cleared without reset");

  a_bad_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.kind != K_BAD |-> out.bad_byte == 8'd0)
    else $error("bad_byte set on non-error token");

endmodule

>>> sv/stt_queue.sv
module stt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  stt_pkg::in_item_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output stt_pkg::in_item_t rd_data
);
  import stt_pkg::*;

  in_item_t mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp;
  logic [QUEUE_AW-1:0] rp;
  logic [QUEUE_AW:0] count;
  logic wr;
  logic rd;

  assign wr_ready = count != (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wr_data;
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + (QUEUE_AW+1)'(wr) - (QUEUE_AW+1)'(rd);
    end
  end

endmodule

>>> sv/stt_scan.sv
module stt_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  stt_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output stt_pkg::tok_t     out_data,
  output logic              stopped
);
  import stt_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_STRING, M_INT, M_IDENT
  } mode_t;

  mode_t mode, mode_next;
  logic [1:0] nlp, nlp_next;
  logic [7:0] prev;
  logic [LINE_BITS-1:0] line, line_next, sline, sline_next;
  logic [COLUMN_BITS-1:0] col, col_next, scol, scol_next;
  logic [OFFSET_BITS-1:0] offs, soff, soff_next;
  logic stop_next;

  tok_t hold;
  logic hold_valid;
  tok_t t0, t1;
  logic n0, n1;
  logic take;
  logic [7:0] c;
  logic idle_path;
  logic [OFFSET_BITS-1:0] diff;
  logic [LEN_BITS-1:0] tlen;
  logic is_dig, is_alp, is_nl, is_ws;
  logic [3:0] pk;
  logic [LINE_BITS-1:0] line_inc;
  logic [COLUMN_BITS-1:0] col_inc;

  assign c = in_data.ch;
  assign is_dig = c >= "0" && c <= "9";
  assign is_alp = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_nl = c == 8'h0D || c == 8'h0A;
  assign is_ws = c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
  assign line_inc = (line < LINE_MAX) ? line + 1'b1 : line;
  assign col_inc = (col < COL_MAX) ? col + 1'b1 : col;
  assign diff = offs - soff;
  assign tlen = (diff > OFFSET_BITS'(16'hFFFF)) ? LEN_BITS'(16'hFFFF) : diff[LEN_BITS-1:0];

  assign in_ready = !hold_valid && (!out_valid || out_ready);
  assign take = in_valid && in_ready;

  always_comb begin
    case (c)
      "(": pk = K_LPAREN;
      ")": pk = K_RPAREN;
      "{": pk = K_LBRACE;
      "}": pk = K_RBRACE;
      ",": pk = K_COMMA;
      default: pk = K_END;
    endcase
  end

  always_comb begin
    mode_next = mode;
    nlp_next = 2'd0;
    line_next = line;
    col_next = col;
    sline_next = sline;
    scol_next = scol;
    soff_next = soff;
    stop_next = stopped;
    n0 = 1'b0;
    n1 = 1'b0;
    t0 = '0;
    t1 = '0;
    idle_path = 1'b0;
    t0.start_line = sline;
    t0.start_col = scol;
    t0.end_line = line;
    t0.end_col = col;
    t0.text_offset = soff;
    t0.text_length = tlen;
    if (in_data.is_end) begin
      case (mode)
        M_SLASH: begin
          n0 = 1'b1; t0.kind = K_BAD; t0.text_length = '0; t0.bad_byte = "/";
        end
        M_STRING: begin
          n0 = 1'b1; t0.kind = K_OPEN;
        end
        default: begin
          n0 = mode == M_INT || mode == M_IDENT;
          t0.kind = (mode == M_INT) ? K_INT : K_IDENT;
          n1 = 1'b1;
          t1.kind = K_END;
          t1.start_line = line;
          t1.start_col = col;
          t1.end_line = line;
          t1.end_col = col;
          t1.text_offset = offs;
          sline_next = line;
          scol_next = col;
          soff_next = offs;
        end
      endcase
      stop_next = 1'b1;
    end else if ((nlp == 2'd1 && c == 8'h0A) || (nlp == 2'd2 && c == 8'h0D)) begin
      nlp_next = 2'd0;
    end else begin
      case (mode)
        M_IDLE: idle_path = 1'b1;
        M_SLASH: begin
          if (c == "/" || c == "*") begin
            col_next = col_inc;
            mode_next = (c == "/") ? M_LINE : M_BLOCK;
          end else begin
            stop_next = 1'b1;
            n0 = 1'b1; t0.kind = K_BAD; t0.text_length = '0; t0.bad_byte = "/";
          end
        end
        M_LINE: begin
          if (is_nl) mode_next = M_IDLE;
          else col_next = col_inc;
        end
        M_BLOCK, M_BSTAR: begin
          if (is_nl) mode_next = M_BLOCK;
          else begin
            col_next = col_inc;
            if (c == "/" && mode == M_BSTAR) mode_next = M_IDLE;
            else mode_next = (c == "*") ? M_BSTAR : M_BLOCK;
          end
        end
        M_STRING: begin
          if (!is_nl) begin
            col_next = col_inc;
            if (c == 8'h22 && prev != 8'h5C) begin
              mode_next = M_IDLE;
              n0 = 1'b1; t0.kind = K_STRING; t0.end_col = col_inc;
            end
          end
        end
        default: begin
          if (is_dig || (mode == M_IDENT && is_alp)) col_next = col_inc;
          else begin
            n0 = 1'b1;
            t0.kind = (mode == M_INT) ? K_INT : K_IDENT;
            mode_next = M_IDLE;
            idle_path = 1'b1;
          end
        end
      endcase
      if (is_nl && mode != M_SLASH && !idle_path &&
          (mode == M_LINE || mode == M_BLOCK || mode == M_BSTAR || mode == M_STRING)) begin
        line_next = line_inc;
        col_next = COLUMN_BITS'(1);
        nlp_next = (c == 8'h0D) ? 2'd1 : 2'd2;
      end
      if (idle_path) begin
        if (is_nl) begin
          line_next = line_inc;
          col_next = COLUMN_BITS'(1);
          nlp_next = (c == 8'h0D) ? 2'd1 : 2'd2;
        end else if (is_ws) begin
          col_next = col_inc;
        end else begin
          col_next = col_inc;
          sline_next = line;
          scol_next = col;
          soff_next = offs;
          t1.start_line = line;
          t1.start_col = col;
          t1.end_line = line;
          t1.end_col = col_inc;
          t1.text_offset = offs;
          if (pk != K_END) begin
            n1 = 1'b1; t1.kind = pk;
          end else if (c == "/") mode_next = M_SLASH;
          else if (c == 8'h22) begin
            mode_next = M_STRING; soff_next = offs + 1'b1;
          end else if (is_dig) mode_next = M_INT;
          else if (is_alp) mode_next = M_IDENT;
          else begin
            n1 = 1'b1; t1.kind = K_BAD; t1.bad_byte = c; stop_next = 1'b1;
          end
        end
      end
    end
    if (!n0) t0 = t1;
    t0.last = !(n0 && n1);
    t1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (take && !stopped) begin
      out_data <= t0;
      hold <= t1;
    end else if (out_valid && out_ready && hold_valid) begin
      out_data <= hold;
    end
    if (rst) begin
      mode <= M_IDLE;
      nlp <= 2'd0;
      prev <= '0;
      line <= LINE_BITS'(1);
      col <= COLUMN_BITS'(1);
      sline <= LINE_BITS'(1);
      scol <= COLUMN_BITS'(1);
      offs <= '0;
      soff <= '0;
      stopped <= 1'b0;
      out_valid <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (out_valid && out_ready && hold_valid) begin
        out_valid <= 1'b1;
        hold_valid <= 1'b0;
      end
      if (take && !stopped) begin
        mode <= mode_next;
        nlp <= nlp_next;
        line <= line_next;
        col <= col_next;
        sline <= sline_next;
        scol <= scol_next;
        soff <= soff_next;
        stopped <= stop_next;
        if (!in_data.is_end) begin
          prev <= c;
          offs <= offs + 1'b1;
        end
        out_valid <= n0 || n1;
        hold_valid <= n0 && n1;
      end
    end
  end

endmodule
